// File: hdl/gbff_pkg.sv
// ----------------------------------------------------------------------------
// gbff_pkg
// Shared types and constants of the grouped bitmap first-free allocator.
// ----------------------------------------------------------------------------
package gbff_pkg;

    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;
    localparam int REM_W  = 16;

    typedef struct packed {
        logic              hit;
        logic [BIT_W-1:0]  bit_idx;
        logic [WORD_W-1:0] new_word;
    } scan_res_t;

endpackage

// File: hdl/gbff_ram.sv
// ----------------------------------------------------------------------------
// gbff_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/gbff_scan.sv
// ----------------------------------------------------------------------------
// gbff_scan
// Finds the lowest clear bit of a bitmap word within the scanned range and
// sets it.
// ----------------------------------------------------------------------------
module gbff_scan
    import gbff_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [REM_W-1:0]  remain,
    output scan_res_t         res
);

    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] free_bits;
    logic [BIT_W-1:0]  idx;

    always_comb
    begin
        // bits past the end of the group are treated as used
        if (remain >= REM_W'(WORD_W))
        begin
            valid_mask = '1;
        end
        else
        begin
            valid_mask = (WORD_W'(1) << remain[BIT_W-1:0]) - WORD_W'(1);
        end
        free_bits = ~word & valid_mask;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                idx = BIT_W'(i);
            end
        end
        res.hit      = |free_bits;
        res.bit_idx  = idx;
        res.new_word = word | (WORD_W'(1) << idx);
    end

endmodule

// File: hdl/grouped_bitmap_first_free_allocator_top.sv
// ----------------------------------------------------------------------------
// grouped_bitmap_first_free_allocator_top
// First-fit allocator over grouped inode and block bitmaps held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one request per transaction; tuser selects the
//   kind (load inode word, load block word, allocate inode, allocate block).
//   Loads write a 64-bit bitmap word; allocations scan the selected map from
//   group 0 upward, lowest bit first, claim the first clear bit and return its
//   number together with the updated word for write-back.
//   Every request yields exactly one transaction on the master stream.
// Sequencing:
//   An allocation visits one bitmap word at a time: a read state waits for
//   the registered RAM read, then an evaluate state scans the word. One
//   request is in flight at a time.
// Reset:
//   Both maps are cleared by a pass that writes one word of each RAM per
//   cycle over GROUPS * max(words per group) addresses (512 by default);
//   s_tready stays low meanwhile. Configuration writes are taken at any time.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits, but a new result is held back until the old one is taken.
// ----------------------------------------------------------------------------
module grouped_bitmap_first_free_allocator_top
    import gbff_pkg::*;
#(
    parameter int GROUPS               = 8,
    parameter int INODE_BITS_PER_GROUP = 2048,
    parameter int BLOCK_BITS_PER_GROUP = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // group[2:0], word_index[8:3], word_data[72:9]
    input  logic [1:0]  s_tuser,  // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata   // number[15:0], found[16], out_group[19:17],
                                  // out_word_index[25:20], out_word[89:26]
);

    localparam int IW    = (INODE_BITS_PER_GROUP + WORD_W - 1) / WORD_W;
    localparam int BW    = (BLOCK_BITS_PER_GROUP + WORD_W - 1) / WORD_W;
    localparam int IDEP  = GROUPS * IW;
    localparam int BDEP  = GROUPS * BW;
    localparam int IAW   = $clog2(IDEP);
    localparam int BAW   = $clog2(BDEP);
    localparam int CDEP  = (IDEP > BDEP) ? IDEP : BDEP;
    localparam int CLW   = $clog2(CDEP + 1);
    localparam int GCW   = $clog2(GROUPS + 1);
    localparam int WCW   = $clog2(((IW > BW) ? IW : BW) + 1);

    localparam logic [1:0] KIND_LOAD_INODE  = 2'd0;
    localparam logic [1:0] KIND_LOAD_BLOCK  = 2'd1;
    localparam logic [1:0] KIND_ALLOC_INODE = 2'd2;
    localparam logic [1:0] KIND_ALLOC_BLOCK = 2'd3;

    localparam logic [1:0] REG_GROUP_COUNT = 2'd0;
    localparam logic [1:0] REG_INODES_PG   = 2'd1;
    localparam logic [1:0] REG_BLOCKS_PG   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    // configuration
    logic [3:0]  group_count_reg;
    logic [11:0] inodes_pg_reg;
    logic [12:0] blocks_pg_reg;

    // control and scan state
    state_t            state_reg;
    logic [CLW-1:0]    clr_reg;
    logic              sel_block_reg;
    logic [GCW-1:0]    g_reg;
    logic [GCW-1:0]    ng_reg;
    logic [WCW-1:0]    w_reg;
    logic [REM_W-1:0]  off_reg;
    logic [REM_W-1:0]  limit_reg;
    logic [REM_W-1:0]  stride_reg;

    // pending result and output register
    logic [15:0]       res_num_reg;
    logic              res_found_reg;
    logic [2:0]        res_group_reg;
    logic [5:0]        res_widx_reg;
    logic [WORD_W-1:0] res_word_reg;
    logic              out_valid_reg;
    logic [95:0]       out_data_reg;

    // request fields
    logic [1:0]        in_kind;
    logic [2:0]        in_group;
    logic [5:0]        in_widx;
    logic [WORD_W-1:0] in_word;
    logic              accept;
    logic              out_free;

    // clamped configuration
    logic [REM_W-1:0]  ipg_clamp;
    logic [REM_W-1:0]  bpg_clamp;
    logic [GCW-1:0]    ng_clamp;

    // RAM ports
    logic              i_we;
    logic [IAW-1:0]    i_waddr;
    logic [IAW-1:0]    i_raddr;
    logic [WORD_W-1:0] i_wdata;
    logic [WORD_W-1:0] i_rdata;
    logic              b_we;
    logic [BAW-1:0]    b_waddr;
    logic [BAW-1:0]    b_raddr;
    logic [WORD_W-1:0] b_wdata;
    logic [WORD_W-1:0] b_rdata;

    logic              load_in_range_i;
    logic              load_in_range_b;
    logic [IAW-1:0]    load_addr_i;
    logic [BAW-1:0]    load_addr_b;
    logic [IAW-1:0]    scan_addr_i;
    logic [BAW-1:0]    scan_addr_b;

    scan_res_t         scan;
    logic [WORD_W-1:0] scan_word;
    logic [REM_W-1:0]  scan_remain;
    logic [15:0]       scan_number;
    logic [REM_W-1:0]  off_next;
    logic              last_word;
    logic              last_group;

    assign in_kind  = s_tuser;
    assign in_group = s_tdata[2:0];
    assign in_widx  = s_tdata[8:3];
    assign in_word  = s_tdata[72:9];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        if (32'(inodes_pg_reg) > INODE_BITS_PER_GROUP)
            ipg_clamp = REM_W'(INODE_BITS_PER_GROUP);
        else
            ipg_clamp = REM_W'(inodes_pg_reg);
        if (32'(blocks_pg_reg) > BLOCK_BITS_PER_GROUP)
            bpg_clamp = REM_W'(BLOCK_BITS_PER_GROUP);
        else
            bpg_clamp = REM_W'(blocks_pg_reg);
        if (32'(group_count_reg) > GROUPS)
            ng_clamp = GCW'(GROUPS);
        else
            ng_clamp = GCW'(group_count_reg);
    end

    // address decode for loads and scan reads
    assign load_in_range_i = (32'(in_group) < GROUPS) && (32'(in_widx) < IW);
    assign load_in_range_b = (32'(in_group) < GROUPS) && (32'(in_widx) < BW);
    assign load_addr_i = IAW'(32'(in_group) * IW + 32'(in_widx));
    assign load_addr_b = BAW'(32'(in_group) * BW + 32'(in_widx));
    assign scan_addr_i = IAW'(32'(g_reg) * IW + 32'(w_reg));
    assign scan_addr_b = BAW'(32'(g_reg) * BW + 32'(w_reg));
    assign i_raddr     = scan_addr_i;
    assign b_raddr     = scan_addr_b;

    // write port muxing: clearing pass, loads, claimed bit write-back
    always_comb
    begin
        i_we    = 1'b0;
        i_waddr = scan_addr_i;
        i_wdata = scan.new_word;
        b_we    = 1'b0;
        b_waddr = scan_addr_b;
        b_wdata = scan.new_word;
        unique case (state_reg)
            ST_CLEAR:
            begin
                i_we    = (32'(clr_reg) < IDEP);
                i_waddr = IAW'(clr_reg);
                i_wdata = '0;
                b_we    = (32'(clr_reg) < BDEP);
                b_waddr = BAW'(clr_reg);
                b_wdata = '0;
            end
            ST_IDLE:
            begin
                i_we    = accept && (in_kind == KIND_LOAD_INODE) && load_in_range_i;
                i_waddr = load_addr_i;
                i_wdata = in_word;
                b_we    = accept && (in_kind == KIND_LOAD_BLOCK) && load_in_range_b;
                b_waddr = load_addr_b;
                b_wdata = in_word;
            end
            ST_EVAL:
            begin
                i_we = scan.hit && !sel_block_reg;
                b_we = scan.hit && sel_block_reg;
            end
            default:
            begin
            end
        endcase
    end

    gbff_ram #(.WIDTH(WORD_W), .DEPTH(IDEP)) u_inode_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    gbff_ram #(.WIDTH(WORD_W), .DEPTH(BDEP)) u_block_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign scan_word   = sel_block_reg ? b_rdata : i_rdata;
    assign scan_remain = limit_reg - off_reg;

    gbff_scan u_scan (
        .word   (scan_word),
        .remain (scan_remain),
        .res    (scan)
    );

    // number = group * stride + bit offset (+1 for inodes), kept to 16 bits
    assign scan_number = 16'(32'(g_reg) * 32'(stride_reg) + 32'(off_reg)
                             + 32'(scan.bit_idx) + 32'(!sel_block_reg));
    assign off_next    = off_reg + REM_W'(WORD_W);
    assign last_word   = (off_next >= limit_reg);
    assign last_group  = (32'(g_reg) + 1 >= 32'(ng_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= 4'd8;
            inodes_pg_reg   <= 12'd2048;
            blocks_pg_reg   <= 13'd4096;
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GROUP_COUNT: group_count_reg <= cfg_data[3:0];
                    REG_INODES_PG:   inodes_pg_reg   <= cfg_data[11:0];
                    REG_BLOCKS_PG:   blocks_pg_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // drop the taken result unless a new one replaces it this cycle
            if (out_valid_reg && m_tready && !((state_reg == ST_DONE) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    // sweep both maps to zero
                    clr_reg <= clr_reg + CLW'(1);
                    if (32'(clr_reg) == CDEP - 1)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_num_reg   <= '0;
                        res_found_reg <= 1'b0;
                        case (in_kind)
                            KIND_LOAD_INODE:
                            begin
                                res_group_reg <= in_group;
                                res_widx_reg  <= in_widx;
                                res_word_reg  <= load_in_range_i ? in_word : '0;
                                state_reg     <= ST_DONE;
                            end
                            KIND_LOAD_BLOCK:
                            begin
                                res_group_reg <= in_group;
                                res_widx_reg  <= in_widx;
                                res_word_reg  <= load_in_range_b ? in_word : '0;
                                state_reg     <= ST_DONE;
                            end
                            default:
                            begin
                                res_group_reg <= '0;
                                res_widx_reg  <= '0;
                                res_word_reg  <= '0;
                                sel_block_reg <= (in_kind == KIND_ALLOC_BLOCK);
                                g_reg         <= '0;
                                w_reg         <= '0;
                                off_reg       <= '0;
                                ng_reg        <= ng_clamp;
                                if (in_kind == KIND_ALLOC_BLOCK)
                                begin
                                    stride_reg <= bpg_clamp;
                                    limit_reg  <= bpg_clamp;
                                end
                                else
                                begin
                                    stride_reg <= ipg_clamp;
                                    limit_reg  <= ipg_clamp & ~REM_W'(7);
                                end
                                // nothing to scan: report not found at once
                                if ((ng_clamp == '0) ||
                                    ((in_kind == KIND_ALLOC_BLOCK) ? (bpg_clamp == '0)
                                        : ((ipg_clamp & ~REM_W'(7)) == '0)))
                                    state_reg <= ST_DONE;
                                else
                                    state_reg <= ST_READ;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (scan.hit)
                    begin
                        res_num_reg   <= scan_number;
                        res_found_reg <= 1'b1;
                        res_group_reg <= 3'(g_reg);
                        res_widx_reg  <= 6'(w_reg);
                        res_word_reg  <= scan.new_word;
                        state_reg     <= ST_DONE;
                    end
                    else if (last_word)
                    begin
                        if (last_group)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            g_reg     <= g_reg + GCW'(1);
                            w_reg     <= '0;
                            off_reg   <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        w_reg     <= w_reg + WCW'(1);
                        off_reg   <= off_next;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    // hold the result until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, res_word_reg, res_widx_reg, res_group_reg,
                                          res_found_reg, res_num_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
